### hw/rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// HTTP chunked body decoder package
// Shared widths, parameter defaults and transfer types for the decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int DEF_SIZE_BITS   = 32;
  localparam int DEF_LENGTH_BITS = 31;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int LENGTH_W = 31;

  // One input transfer: a body byte or the end-of-body command.
  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] in_byte;
  } hcbd_item_t;

  // One result transfer: a data byte or the closing status.
  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                final_res;
    logic [STATUS_W-1:0] status;
    logic [LENGTH_W-1:0] decoded_length;
  } hcbd_res_t;

endpackage

### hw/rtl/hcbd_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one input transfer whenever it is empty or the decoder stage can move on.
// ----------------------------------------------------------------------------
module hcbd_in_stage import hcbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  hcbd_item_t in_item,
  input  logic       advance,
  output logic       item_valid,
  output hcbd_item_t item
);

  logic       valid_r;
  logic       valid_nxt;
  hcbd_item_t item_r;
  logic       load;

  // The register is free when empty or when its item moves on this cycle.
  assign load     = !valid_r || advance;
  assign in_stall = !load;
  assign valid_nxt = load ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### hw/rtl/hcbd_core.sv
// ----------------------------------------------------------------------------
// Chunked decoding state machine
// Walks the size line, data, line ends and trailer one byte per transfer.
// ----------------------------------------------------------------------------
module hcbd_core import hcbd_pkg::*; #(
  parameter int SIZE_BITS   = DEF_SIZE_BITS,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  hcbd_item_t item,
  input  logic       advance,
  output logic       res_valid,
  output hcbd_res_t  res
);

  localparam logic [3:0] PH_SIZE_START  = 4'd0;
  localparam logic [3:0] PH_SIZE_DIGITS = 4'd1;
  localparam logic [3:0] PH_SIZE_EXT    = 4'd2;
  localparam logic [3:0] PH_DATA        = 4'd3;
  localparam logic [3:0] PH_AFTER_DATA  = 4'd4;
  localparam logic [3:0] PH_AFTER_CR    = 4'd5;
  localparam logic [3:0] PH_TRL_START   = 4'd6;
  localparam logic [3:0] PH_TRL_CR      = 4'd7;
  localparam logic [3:0] PH_TRL_BODY    = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_DATA_END = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_TRAILER = 3'd4;

  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

  logic [3:0]             phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]   size_r, size_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic                   done_r, done_nxt;

  logic                   hex_ok;
  logic [3:0]             hex_val;
  logic                   fin;
  logic [STATUS_W-1:0]    fin_status;
  logic                   emit;
  logic [SIZE_BITS-1:0]   left_dec;
  logic [LENGTH_BITS+LENGTH_W-1:0] count_ext;
  logic [BYTE_W-1:0]      c;

  assign c = item.in_byte;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign left_dec = (size_r != '0) ? size_r - 1'b1 : size_r;

  always_comb begin
    phase_nxt  = phase_r;
    size_nxt   = size_r;
    count_nxt  = count_r;
    done_nxt   = done_r;
    fin        = 1'b0;
    fin_status = ST_OK;
    emit       = 1'b0;
    if (item_valid && !done_r) begin
      if (item.command) begin
        fin = 1'b1;
        case (phase_r)
          PH_DATA:                             fin_status = ST_TRUNCATED;
          PH_AFTER_DATA, PH_AFTER_CR:          fin_status = ST_NO_DATA_END;
          PH_TRL_START, PH_TRL_CR, PH_TRL_BODY: fin_status = ST_BAD_TRAILER;
          default:                             fin_status = ST_BAD_SIZE;
        endcase
      end else begin
        case (phase_r)
          PH_SIZE_START: begin
            if (!hex_ok) begin
              fin        = 1'b1;
              fin_status = ST_BAD_SIZE;
            end else begin
              size_nxt  = SIZE_BITS'(hex_val);
              phase_nxt = PH_SIZE_DIGITS;
            end
          end
          PH_SIZE_DIGITS: begin
            if (hex_ok) begin
              size_nxt = {size_r[SIZE_BITS-5:0], hex_val};
            end else if (c == CH_LF) begin
              phase_nxt = (size_r == '0) ? PH_TRL_START : PH_DATA;
            end else begin
              phase_nxt = PH_SIZE_EXT;
            end
          end
          PH_SIZE_EXT: begin
            if (c == CH_LF) begin
              phase_nxt = (size_r == '0) ? PH_TRL_START : PH_DATA;
            end
          end
          PH_DATA: begin
            emit     = 1'b1;
            size_nxt = left_dec;
            if (count_r != '1) begin
              count_nxt = count_r + 1'b1;
            end
            if (left_dec == '0) begin
              phase_nxt = PH_AFTER_DATA;
            end
          end
          PH_AFTER_DATA: begin
            if (c == CH_LF) begin
              phase_nxt = PH_SIZE_START;
            end else if (c == CH_CR) begin
              phase_nxt = PH_AFTER_CR;
            end else begin
              fin        = 1'b1;
              fin_status = ST_NO_DATA_END;
            end
          end
          PH_AFTER_CR: begin
            if (c == CH_LF) begin
              phase_nxt = PH_SIZE_START;
            end else begin
              fin        = 1'b1;
              fin_status = ST_NO_DATA_END;
            end
          end
          PH_TRL_START: begin
            if (c == CH_LF) begin
              fin = 1'b1;
            end else begin
              phase_nxt = (c == CH_CR) ? PH_TRL_CR : PH_TRL_BODY;
            end
          end
          PH_TRL_CR: begin
            if (c == CH_LF) begin
              fin = 1'b1;
            end else begin
              phase_nxt = PH_TRL_BODY;
            end
          end
          PH_TRL_BODY: begin
            if (c == CH_LF) begin
              phase_nxt = PH_TRL_START;
            end
          end
          default: begin
            phase_nxt  = PH_SIZE_START;
            fin        = 1'b1;
            fin_status = ST_BAD_SIZE;
          end
        endcase
      end
      if (fin) begin
        done_nxt = 1'b1;
      end
    end
  end

  // The count may be narrower or wider than the length field.
  assign count_ext = {{LENGTH_W{1'b0}}, count_r};

  always_comb begin
    res_valid          = fin || emit;
    res.out_byte       = emit ? c : '0;
    res.final_res      = fin;
    res.status         = fin ? fin_status : ST_OK;
    res.decoded_length = fin ? count_ext[LENGTH_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE_START;
      size_r  <= '0;
      count_r <= '0;
      done_r  <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      size_r  <= size_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

### hw/rtl/hcbd_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result transfer until the receiver takes it.
// ----------------------------------------------------------------------------
module hcbd_out_stage import hcbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  logic      res_valid,
  input  hcbd_res_t res,
  output logic      advance,
  output logic      out_valid,
  input  logic      out_stall,
  output hcbd_res_t out_res
);

  logic      valid_r;
  logic      valid_nxt;
  hcbd_res_t res_r;

  // The decoder stage moves whenever this register is empty or being drained.
  assign advance   = !valid_r || !out_stall;
  assign valid_nxt = advance ? (item_valid && res_valid) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### hw/rtl/http_chunked_body_decoder_unit.sv
// A byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle unless stalled; the state updates in one step.
// A stalled result holds both stages, so the input stalls once its register is full.
// Reset (synchronous, active low) returns to the start of a size line with zero
// counts and clears both stage registers; no item is lost or invented on exit.
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Top level: input register, decoding state machine and result register.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit import hcbd_pkg::*; #(
  parameter int SIZE_BITS   = DEF_SIZE_BITS,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [BYTE_W-1:0]   in_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_final_res,
  output logic [STATUS_W-1:0] out_status,
  output logic [LENGTH_W-1:0] out_decoded_length
);

  hcbd_item_t in_item;
  hcbd_item_t item;
  logic       item_valid;
  logic       advance;
  logic       res_valid;
  hcbd_res_t  res;
  hcbd_res_t  out_res;

  assign in_item.command = in_command;
  assign in_item.in_byte = in_byte;

  hcbd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  hcbd_core #(
    .SIZE_BITS   (SIZE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  hcbd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_byte           = out_res.out_byte;
  assign out_final_res      = out_res.final_res;
  assign out_status         = out_res.status;
  assign out_decoded_length = out_res.decoded_length;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the HTTP chunked body decoder
// Feeds one long chunked body byte by byte, with random chunk sizes, size
// extensions, mixed line ends and trailer lines, and one randomly chosen way
// of closing it. A scoreboard predicts every data byte and the closing status
// and checks them in order against the result channel under random stalls.
// ----------------------------------------------------------------------------
module testbench;
  import hcbd_pkg::*;

  localparam logic [7:0] LF = 8'h0A;
  localparam logic [7:0] CR = 8'h0D;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_DATA_END = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_TRAILER = 3'd4;

  localparam int BODY_ITEMS = 920;
  localparam int LONG_HOLD  = 200;
  localparam int IDLE_LIMIT = 3000;

  typedef enum logic [3:0] {
    PH_SIZE_START, PH_SIZE_DIGITS, PH_SIZE_EXT, PH_DATA, PH_AFTER_DATA,
    PH_AFTER_CR, PH_TRL_START, PH_TRL_CR, PH_TRL_BODY
  } body_phase_e;

  class body_scoreboard;
    body_phase_e                phase;
    logic [DEF_SIZE_BITS-1:0]   chunk_left;
    logic [LENGTH_W-1:0]        byte_count;
    bit                         closed;
    logic [STATUS_W-1:0]        close_status;
    hcbd_res_t                  expected_q[$];
    int                         mismatches;
    int                         data_checked;

    function new();
      phase        = PH_SIZE_START;
      chunk_left   = '0;
      byte_count   = '0;
      closed       = 1'b0;
      close_status = ST_OK;
      mismatches   = 0;
      data_checked = 0;
    endfunction

    static function int digit_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
      return -1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void close_body(logic [STATUS_W-1:0] st);
      hcbd_res_t r;
      r = '0;
      r.final_res = 1'b1;
      r.status = st;
      r.decoded_length = byte_count;
      closed = 1'b1;
      close_status = st;
      expected_q.push_back(r);
    endfunction

    function void end_size_line();
      phase = (chunk_left == 0) ? PH_TRL_START : PH_DATA;
    endfunction

    function void note_input(logic cmd, logic [7:0] c);
      int h;
      hcbd_res_t r;
      if (closed) return;
      if (cmd == CMD_END) begin
        case (phase)
          PH_DATA: close_body(ST_TRUNCATED);
          PH_AFTER_DATA, PH_AFTER_CR: close_body(ST_NO_DATA_END);
          PH_TRL_START, PH_TRL_CR, PH_TRL_BODY: close_body(ST_BAD_TRAILER);
          default: close_body(ST_BAD_SIZE);
        endcase
        return;
      end
      h = digit_value(c);
      case (phase)
        PH_SIZE_START: begin
          if (h < 0) close_body(ST_BAD_SIZE);
          else begin
            chunk_left = h;
            phase = PH_SIZE_DIGITS;
          end
        end
        PH_SIZE_DIGITS: begin
          // The size wraps silently; only the low hex digits survive.
          if (h >= 0) chunk_left = {chunk_left[DEF_SIZE_BITS-5:0], h[3:0]};
          else if (c == LF) end_size_line();
          else phase = PH_SIZE_EXT;
        end
        PH_SIZE_EXT: if (c == LF) end_size_line();
        PH_DATA: begin
          r = '0;
          r.out_byte = c;
          expected_q.push_back(r);
          if (byte_count != '1) byte_count++;
          if (chunk_left != 0) chunk_left--;
          if (chunk_left == 0) phase = PH_AFTER_DATA;
        end
        PH_AFTER_DATA: begin
          if (c == LF) phase = PH_SIZE_START;
          else if (c == CR) phase = PH_AFTER_CR;
          else close_body(ST_NO_DATA_END);
        end
        PH_AFTER_CR: begin
          if (c == LF) phase = PH_SIZE_START;
          else close_body(ST_NO_DATA_END);
        end
        PH_TRL_START: begin
          if (c == LF) close_body(ST_OK);
          else phase = (c == CR) ? PH_TRL_CR : PH_TRL_BODY;
        end
        PH_TRL_CR: begin
          if (c == LF) close_body(ST_OK);
          else phase = PH_TRL_BODY;
        end
        PH_TRL_BODY: if (c == LF) phase = PH_TRL_START;
        default: close_body(ST_BAD_SIZE);
      endcase
    endfunction

    function void check_result(hcbd_res_t got);
      hcbd_res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result: byte %02h final %0b status %0d length %0d",
                   got.out_byte, got.final_res, got.status, got.decoded_length);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte || got.final_res !== want.final_res ||
          got.status !== want.status || got.decoded_length !== want.decoded_length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result differs: expected byte %02h final %0b status %0d length %0d",
                   want.out_byte, want.final_res, want.status, want.decoded_length);
          $display("       got byte %02h final %0b status %0d length %0d",
                   got.out_byte, got.final_res, got.status, got.decoded_length);
        end
      end else if (!want.final_res) begin
        data_checked++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_command = CMD_BYTE;
  logic [BYTE_W-1:0]   in_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_final_res;
  logic [STATUS_W-1:0] out_status;
  logic [LENGTH_W-1:0] out_decoded_length;

  logic hold_off_req = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_left;
  int   seg_left;
  int   idle_cycles = 0;
  int   items_sent = 0;
  bit   burst = 1'b0;

  body_scoreboard sb = new();

  http_chunked_body_decoder_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_final_res      (out_final_res),
    .out_status         (out_status),
    .out_decoded_length (out_decoded_length)
  );

  always #5 clk = ~clk;

  function automatic int free_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
  endfunction

  function automatic int stall_len();
    return ($urandom_range(0, 6) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // Receiver: alternating free and stalled stretches, plus one long hold-off
  // on request from the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      seg_left  <= 4;
    end else if (hold_off_req && !hold_taken) begin
      hold_taken <= 1'b1;
      out_stall  <= 1'b1;
      hold_left  <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) out_stall <= 1'b0;
    end else if (seg_left > 1) begin
      seg_left <= seg_left - 1;
    end else begin
      out_stall <= !out_stall;
      seg_left  <= out_stall ? free_len() : stall_len();
    end
  end

  always @(posedge clk) begin : result_monitor
    hcbd_res_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.out_byte       = out_byte;
      got.final_res      = out_final_res;
      got.status         = out_status;
      got.decoded_length = out_decoded_length;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 95) return $urandom_range(17, 64);
    return $urandom_range(65, 300);
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (body_scoreboard::digit_value(c) >= 0 || c == LF);
    return c;
  endfunction

  function automatic logic [7:0] non_lf_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == LF);
    return c;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == LF || c == CR);
    return c;
  endfunction

  // Valid stays high across back-to-back transfers; this task lowers it only for a gap.
  task automatic send_item(logic cmd, logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_byte    <= c;
    do @(posedge clk);
    while (in_stall);
    sb.note_input(cmd, c);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] c);
    send_item(CMD_BYTE, c);
  endtask

  task automatic send_end();
    send_item(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk);
    while (sb.pending() != 0);
  endtask

  task automatic send_line_end();
    if ($urandom_range(0, 1)) send_byte(CR);
    send_byte(LF);
  endtask

  // A nonzero digit in front of eight digits pushes the size past 32 bits.
  task automatic send_size_digits(logic [31:0] size, bit wrap);
    int nd;
    nd = 1;
    while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
    if (wrap) begin
      send_byte(hex_char($urandom_range(1, 15)));
      nd = 8;
    end else if ($urandom_range(0, 4) == 0) begin
      nd = nd + $urandom_range(1, 2);
    end
    for (int i = nd - 1; i >= 0; i--) send_byte(hex_char((size >> (4 * i)) & 15));
  endtask

  task automatic send_size_line(logic [31:0] size);
    send_size_digits(size, $urandom_range(0, 9) == 0);
    if ($urandom_range(0, 3) == 0) begin
      send_byte(non_hex_byte());
      repeat ($urandom_range(0, 5)) send_byte(non_lf_byte());
    end
    send_line_end();
  endtask

  task automatic send_chunk(int n);
    send_size_line(n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
    send_line_end();
  endtask

  task automatic send_trailer_line();
    if ($urandom_range(0, 2) == 0) begin
      send_byte(CR);
      send_byte(non_lf_byte());
    end else begin
      send_byte(plain_byte());
    end
    repeat ($urandom_range(0, 6)) send_byte(non_lf_byte());
    send_byte(LF);
  endtask

  task automatic close_body_random();
    int n;
    case ($urandom_range(0, 8))
      0, 1, 2, 3: begin
        send_size_line(0);
        repeat ($urandom_range(0, 3)) send_trailer_line();
        send_line_end();
      end
      4: begin
        case ($urandom_range(0, 3))
          0: send_byte(non_hex_byte());
          1: send_end();
          2: begin
            send_size_digits(pick_size(), 1'b0);
            send_end();
          end
          default: begin
            send_size_digits(pick_size(), 1'b0);
            send_byte(non_hex_byte());
            send_end();
          end
        endcase
      end
      5: begin
        n = $urandom_range(1, 12);
        send_size_line(n);
        repeat ($urandom_range(0, n - 1)) send_byte(8'($urandom_range(0, 255)));
        send_end();
      end
      6: begin
        n = $urandom_range(1, 12);
        send_size_line(n);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
          0: send_byte(plain_byte());
          1: begin
            send_byte(CR);
            send_byte(non_lf_byte());
          end
          2: send_end();
          default: begin
            send_byte(CR);
            send_end();
          end
        endcase
      end
      default: begin
        send_size_line(0);
        repeat ($urandom_range(0, 2)) send_trailer_line();
        case ($urandom_range(0, 2))
          0: send_end();
          1: begin
            send_byte(CR);
            send_end();
          end
          default: begin
            repeat ($urandom_range(1, 4)) send_byte(plain_byte());
            send_end();
          end
        endcase
      end
    endcase
  endtask

  initial begin
    int chunk_no;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One-byte chunk with bare LF line ends and an all-ones data byte.
    send_byte(8'h31); send_byte(LF); send_byte(8'hFF); send_byte(LF);
    // Extension on the size line, CRLF line ends, zero and top-bit data bytes.
    send_byte(8'h32); send_byte(8'h3B); send_byte(8'h78); send_byte(CR); send_byte(LF);
    send_byte(8'h00); send_byte(8'h80); send_byte(CR); send_byte(LF);
    // Nine digits: the leading one falls off the 32-bit size, leaving one.
    send_byte(8'h31);
    repeat (7) send_byte(8'h30);
    send_byte(8'h31); send_byte(LF); send_byte(8'h7F); send_byte(LF);
    wait_drained();

    chunk_no = 0;
    while (items_sent < BODY_ITEMS) begin
      burst = ($urandom_range(0, 5) == 0);
      if (chunk_no == 10) wait_drained();
      if (chunk_no == 20) begin
        // Long receiver hold-off while the sender keeps pushing data.
        burst = 1'b1;
        hold_off_req <= 1'b1;
        send_chunk(48);
      end else begin
        send_chunk(pick_size());
      end
      chunk_no++;
    end
    burst = 1'b0;
    close_body_random();

    // Everything after the closing result must be swallowed.
    send_end();
    repeat (11) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d input transfers in one chunked body; %0d data bytes matched.",
             items_sent, sb.data_checked);
    $display("Body closed with status %0d after %0d bytes; %0d result errors.",
             sb.close_status, sb.byte_count, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
